/* hdl/lcdn_pkg.sv */
// Shared constants, types and a helper function for the LCD number writer.
package lcdn_pkg;

    localparam int ACT_W   = 2;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 31;
    localparam int BYTE_W  = 8;

    // Request modes.
    localparam logic [ACT_W-1:0] ACT_CHAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEC  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_HEX  = 2'd3;

    localparam int MAX_DIGITS_DEF = 7;
    localparam int DEC_DIGITS     = 3;

    localparam logic [POS_W-1:0]  INT_OFFSET = 8'd7;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_X    = 8'h78;
    localparam logic [BYTE_W-1:0] ASCII_A    = 8'h41;

    // Reciprocal of ten: floor(v * RECIP / 2^RECIP_SHIFT) == v / 10 for any v below 2^32.
    localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 28;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit_cmd;
        logic emit_data;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pair_last;
    } t_dp_stat;

    // Uppercase hex character for one nibble.
    function automatic logic [BYTE_W-1:0] hex_glyph(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_glyph = ASCII_ZERO + {4'd0, nib};
        end else begin
            hex_glyph = ASCII_A + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

/* hdl/lcdn_req_if.sv */
// Request channel: mode, display position and value with a valid/ready handshake.
interface lcdn_req_if;
    logic                             valid;
    logic                             ready;
    logic [lcdn_pkg::ACT_W-1:0]       action;
    logic [lcdn_pkg::POS_W-1:0]       position;
    logic [lcdn_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

/* hdl/lcdn_wr_if.sv */
// Write channel: one display bus write per transfer with a valid/ready handshake.
interface lcdn_wr_if;
    logic                          valid;
    logic                          ready;
    logic                          is_command;
    logic [lcdn_pkg::BYTE_W-1:0]   write_byte;
    logic                          last;

    modport source (output valid, output is_command, output write_byte, output last, input ready);
    modport sink   (input valid, input is_command, input write_byte, input last, output ready);
endinterface

/* hdl/lcdn_ctrl.sv */
// Controller state machine that sequences address and data writes.
module lcdn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lcdn_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output lcdn_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMD  = 3'b010,
        ST_DATA = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.emit_cmd  = 1'b0;
        o_cmd.emit_data = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CMD;
                end
            end
            ST_CMD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_cmd = 1'b1;
                    n_state        = ST_DATA;
                end
            end
            ST_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_data = 1'b1;
                    n_state         = i_stat.pair_last ? ST_IDLE : ST_CMD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // An accepted request always starts with an address command.
    a_accept_to_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CMD))
        else $error("accepted request did not move to the command step");
`endif

endmodule

/* hdl/lcdn_dp.sv */
// Datapath: request registers, divide-by-ten unit, address stepping and output register.
module lcdn_dp #(
    parameter int MAX_DIGITS = lcdn_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcdn_pkg::t_dp_cmd               i_cmd,
    input  logic [lcdn_pkg::ACT_W-1:0]      i_action,
    input  logic [lcdn_pkg::POS_W-1:0]      i_position,
    input  logic [lcdn_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_out_ready,
    output lcdn_pkg::t_dp_stat              o_stat,
    output logic                            o_out_valid,
    output logic                            o_is_command,
    output logic [lcdn_pkg::BYTE_W-1:0]     o_write_byte,
    output logic                            o_last
);

    localparam int LIM_MAX = (MAX_DIGITS > lcdn_pkg::DEC_DIGITS) ?
                             MAX_DIGITS : lcdn_pkg::DEC_DIGITS;
    localparam int CNT_W   = $clog2(LIM_MAX);
    localparam int PROD_W  = lcdn_pkg::VALUE_W + 32;

    logic [lcdn_pkg::ACT_W-1:0]   r_action;
    logic [lcdn_pkg::POS_W-1:0]   r_addr;
    logic [lcdn_pkg::VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]             r_cnt;
    logic [lcdn_pkg::QUOT_W-1:0]  r_quot;
    logic                         r_out_valid;
    logic                         r_is_command;
    logic [lcdn_pkg::BYTE_W-1:0]  r_write_byte;
    logic                         r_last;

    logic [PROD_W-1:0]            prod;
    logic [3:0]                   tenq_lo;
    logic [3:0]                   rem;
    logic                         is_decimal;
    logic [CNT_W-1:0]             lim_m1;
    logic [lcdn_pkg::BYTE_W-1:0]  data_byte;
    logic                         pair_last;
    logic [lcdn_pkg::POS_W-1:0]   start_addr;
    logic [lcdn_pkg::VALUE_W-1:0] start_val;

    // The quotient is recomputed and registered every cycle; it has settled by the data step,
    // since an address command step always lies between a value register change and that step.
    assign prod = PROD_W'(r_val) * PROD_W'(lcdn_pkg::RECIP);

    // Only the low four bits of 10*q are needed since the remainder is below ten.
    assign tenq_lo = {r_quot[0], 3'b000} + {r_quot[2:0], 1'b0};
    assign rem     = r_val[3:0] - tenq_lo;

    assign is_decimal = (r_action == lcdn_pkg::ACT_DEC) || (r_action == lcdn_pkg::ACT_INT);
    assign lim_m1     = (r_action == lcdn_pkg::ACT_INT) ? CNT_W'(MAX_DIGITS - 1) :
                                                          CNT_W'(lcdn_pkg::DEC_DIGITS - 1);

    always_comb begin
        data_byte = lcdn_pkg::ASCII_ZERO + {4'd0, rem};
        pair_last = (r_quot == '0) || (r_cnt == lim_m1);
        case (r_action)
            lcdn_pkg::ACT_CHAR: begin
                data_byte = r_val[7:0];
                pair_last = 1'b1;
            end
            lcdn_pkg::ACT_HEX: begin
                pair_last = (r_cnt[1:0] == 2'd3);
                case (r_cnt[1:0])
                    2'd0:    data_byte = lcdn_pkg::ASCII_ZERO;
                    2'd1:    data_byte = lcdn_pkg::ASCII_X;
                    2'd2:    data_byte = lcdn_pkg::hex_glyph(r_val[7:4]);
                    default: data_byte = lcdn_pkg::hex_glyph(r_val[3:0]);
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        start_addr = i_position;
        start_val  = i_value;
        case (i_action)
            lcdn_pkg::ACT_INT: begin
                start_addr = i_position + lcdn_pkg::INT_OFFSET;
            end
            lcdn_pkg::ACT_DEC: begin
                start_val = {{(lcdn_pkg::VALUE_W-8){1'b0}}, i_value[7:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_quot <= prod[lcdn_pkg::RECIP_SHIFT +: lcdn_pkg::QUOT_W];
        if (i_cmd.load) begin
            r_action <= i_action;
            r_addr   <= start_addr;
            r_val    <= start_val;
            r_cnt    <= '0;
        end else if (i_cmd.emit_data) begin
            r_cnt  <= r_cnt + 1'b1;
            r_addr <= is_decimal ? (r_addr - 1'b1) : (r_addr + 1'b1);
            if (is_decimal) begin
                r_val <= lcdn_pkg::VALUE_W'(r_quot);
            end
        end
        if (i_cmd.emit_cmd) begin
            r_is_command <= 1'b1;
            r_write_byte <= r_addr;
            r_last       <= 1'b0;
        end else if (i_cmd.emit_data) begin
            r_is_command <= 1'b0;
            r_write_byte <= data_byte;
            r_last       <= pair_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_cmd || i_cmd.emit_data) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.pair_last = pair_last;
    assign o_out_valid      = r_out_valid;
    assign o_is_command     = r_is_command;
    assign o_write_byte     = r_write_byte;
    assign o_last           = r_last;

`ifndef SYNTH
    // The reciprocal multiply must leave a true decimal remainder.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_data && is_decimal) |-> (rem < 4'd10))
        else $error("decimal digit out of range");

    // The digit counter never runs past the digit limit of the mode.
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_data && is_decimal) |-> (r_cnt <= lim_m1))
        else $error("digit counter passed its limit");

    // The final write of a request is always a character write.
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> !r_is_command)
        else $error("last flag set on an address command");
`endif

endmodule

/* hdl/lcd_number_to_char_writes.sv */
// Top level of the LCD number writer: request port, controller, datapath and write port.
//
// Each request carries a mode (char, decimal byte, decimal integer or hex byte),
// a display address and a value, and the block answers with the sequence of
// character-LCD bus writes that shows it: every character is preceded by an
// address command write, and the last character write of a request carries
// the last flag. Char mode writes one character, decimal byte mode one to
// three digits at descending addresses from the given one, integer mode one
// to MAX_DIGITS digits starting seven addresses above the given one and going
// down, stopping when no higher nonzero digit remains, and hex mode "0x" and
// two uppercase digits at ascending addresses. All addresses wrap at 256.
// The block emits at most one write per cycle and works on one request at a
// time, stepping from acceptance through an address command step and a data
// step for each character; stalls at the write port hold up those steps.
// Digits come from a single reciprocal multiplier that divides the working
// value by ten once per digit. A new request is taken as soon as the
// previous request's final write has been placed in the output register,
// even while that write still waits.
module lcd_number_to_char_writes #(
    parameter int MAX_DIGITS = lcdn_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lcdn_req_if.sink       i_req,
    lcdn_wr_if.source      o_wr
);

    lcdn_pkg::t_dp_cmd  cmd;
    lcdn_pkg::t_dp_stat stat;
    logic               in_ready;

    // The controller decides when to load a request and when to emit each write.
    lcdn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // The datapath holds the request, derives each byte and drives the write port.
    lcdn_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_req.action),
        .i_position   (i_req.position),
        .i_value      (i_req.value),
        .i_out_ready  (o_wr.ready),
        .o_stat       (stat),
        .o_out_valid  (o_wr.valid),
        .o_is_command (o_wr.is_command),
        .o_write_byte (o_wr.write_byte),
        .o_last       (o_wr.last)
    );

    assign i_req.ready = in_ready;

endmodule

/* test/lcd_write_checker.sv */
// Checker for the LCD number writer: predicts each request's bus writes and compares them.
module lcd_write_checker #(
    parameter int MAX_DIGITS = lcdn_pkg::MAX_DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lcdn_req_if  i_req,
    lcdn_wr_if   i_wr,
    output int   o_fail_count,
    output int   o_pending
);
    import lcdn_pkg::*;

    localparam int MAX_PAIRS = (MAX_DIGITS > 4) ? MAX_DIGITS : 4;

    typedef struct packed {
        logic              is_command;
        logic [BYTE_W-1:0] write_byte;
        logic              last;
    } lcd_write_t;

    lcd_write_t expected_writes[$];
    int         mismatches = 0;

    function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return ASCII_ZERO + {4'd0, nib};
        end
        return ASCII_A + {4'd0, nib} - 8'd10;
    endfunction

    // Every character goes out as an address command followed by its data write.
    task automatic predict_writes(input logic [ACT_W-1:0]   act,
                                  input logic [POS_W-1:0]   pos,
                                  input logic [VALUE_W-1:0] val);
        logic [POS_W-1:0]   addr  [MAX_PAIRS];
        logic [BYTE_W-1:0]  glyph [MAX_PAIRS];
        logic [BYTE_W-1:0]  b;
        logic [VALUE_W-1:0] rest;
        int                 n;
        b = val[BYTE_W-1:0];
        n = 0;
        case (act)
            ACT_CHAR: begin
                addr[0] = pos;
                glyph[0] = b;
                n = 1;
            end
            ACT_DEC: begin
                addr[0] = pos;
                glyph[0] = ASCII_ZERO + b % 8'd10;
                n = 1;
                if (b > 8'd9) begin
                    addr[1] = pos - 8'd1;
                    glyph[1] = ASCII_ZERO + (b / 8'd10) % 8'd10;
                    n = 2;
                end
                if (b > 8'd99) begin
                    addr[2] = pos - 8'd2;
                    glyph[2] = ASCII_ZERO + b / 8'd100;
                    n = 3;
                end
            end
            ACT_INT: begin
                rest = val;
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    addr[n] = pos + INT_OFFSET - POS_W'(i);
                    glyph[n] = ASCII_ZERO + BYTE_W'(rest % 31'd10);
                    n++;
                    rest = rest / 31'd10;
                    if (rest == '0) begin
                        break;
                    end
                end
            end
            default: begin
                addr[0] = pos;
                glyph[0] = ASCII_ZERO;
                addr[1] = pos + 8'd1;
                glyph[1] = ASCII_X;
                addr[2] = pos + 8'd2;
                glyph[2] = nibble_char(b[7:4]);
                addr[3] = pos + 8'd3;
                glyph[3] = nibble_char(b[3:0]);
                n = 4;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            expected_writes.push_back('{is_command: 1'b1, write_byte: addr[k], last: 1'b0});
            expected_writes.push_back('{is_command: 1'b0, write_byte: glyph[k],
                                        last: (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin : watch
        lcd_write_t seen;
        lcd_write_t want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                predict_writes(i_req.action, i_req.position, i_req.value);
            end
            if (i_wr.valid && i_wr.ready) begin
                seen = '{is_command: i_wr.is_command, write_byte: i_wr.write_byte,
                         last: i_wr.last};
                if (expected_writes.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: write with none pending: cmd=%0b byte=%02h last=%0b",
                                 $realtime, seen.is_command, seen.write_byte, seen.last);
                    end
                    mismatches++;
                end else begin
                    want = expected_writes.pop_front();
                    if (seen !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: write mismatch", $realtime);
                            $display("    expected cmd=%0b byte=%02h last=%0b",
                                     want.is_command, want.write_byte, want.last);
                            $display("    got      cmd=%0b byte=%02h last=%0b",
                                     seen.is_command, seen.write_byte, seen.last);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_writes.size();
    end

endmodule

/* test/tb_lcd_number_to_char_writes.sv */
// Testbench top for the LCD number writer: clock, reset, request stimulus and verdict.
module tb_lcd_number_to_char_writes;
    import lcdn_pkg::*;

    // Chance in percent that either side idles in a given cycle.
    localparam int IDLE_PCT       = 19;
    localparam int RANDOM_ITEMS   = 390;
    // Cycles with no request and no write accepted before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Grace period after the last expected write, longer than the longest request.
    localparam int TAIL_CYCLES    = 2 * MAX_DIGITS_DEF + 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // While set, neither the request side nor the write side idles.
    bit calm = 1'b0;

    int fail_count;
    int pending_count;
    int stuck_cycles = 0;

    lcdn_req_if req_ch();
    lcdn_wr_if  wr_ch();

    lcd_number_to_char_writes dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_wr    (wr_ch)
    );

    // The checker sees both channels and predicts every write on its own.
    lcd_write_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_wr         (wr_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: any accepted request or write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // The display side stalls at random, except during the calm stretch.
    initial begin
        wr_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            wr_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Called at a falling edge. The request may be preceded by random idle cycles,
    // and it is held until the block takes it; the task returns at the next falling
    // edge, so back-to-back requests keep valid high without a gap.
    task automatic send_request(input logic [ACT_W-1:0]   act,
                                input logic [POS_W-1:0]   pos,
                                input logic [VALUE_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= val;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off new requests until every predicted write has been seen.
    task automatic drain_writes();
        req_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Positions favor both ends so that address wrap is hit often.
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(7))
            0, 1:    return POS_W'($urandom_range(255, 248));
            2:       return POS_W'($urandom_range(3));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Integer mode gets a spread of magnitudes, including values around the
    // seven-digit limit where the top digits are dropped. The other modes only
    // look at the low byte, so the upper bits are left random as noise.
    function automatic logic [VALUE_W-1:0] pick_value(input logic [ACT_W-1:0] act);
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom);
        if (act == ACT_INT) begin
            case ($urandom_range(5))
                0:       v = VALUE_W'($urandom_range(9));
                1:       v = VALUE_W'($urandom_range(9999));
                2:       v = VALUE_W'($urandom_range(9999999));
                3:       v = VALUE_W'($urandom_range(10000005, 9999995));
                default: ;
            endcase
        end
        return v;
    endfunction

    initial begin
        logic [ACT_W-1:0] act;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_CHAR;
        req_ch.position <= '0;
        req_ch.value    <= '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Char mode at both ends of the fields; upper value bits
        // must be ignored.
        send_request(ACT_CHAR, 8'd0,   31'd0);
        send_request(ACT_CHAR, 8'd255, 31'h7FFF_FFFF);
        // Decimal byte: one, two and three digits, with the higher digits
        // wrapping below address zero.
        send_request(ACT_DEC, 8'd5,  31'd0);
        send_request(ACT_DEC, 8'd5,  31'd9);
        send_request(ACT_DEC, 8'd5,  31'd10);
        send_request(ACT_DEC, 8'd0,  31'd99);
        send_request(ACT_DEC, 8'd1,  31'd100);
        send_request(ACT_DEC, 8'd0,  31'd255);
        send_request(ACT_DEC, 8'd7,  31'h7FFF_FF05);
        // Decimal integer: zero as a single digit, digit-count boundaries, the
        // start address wrapping past 255, and digits above seven dropped.
        send_request(ACT_INT, 8'd0,   31'd0);
        send_request(ACT_INT, 8'd0,   31'd9);
        send_request(ACT_INT, 8'd3,   31'd10);
        send_request(ACT_INT, 8'd249, 31'd9999999);
        send_request(ACT_INT, 8'd255, 31'd10000000);
        send_request(ACT_INT, 8'd128, 31'd2147483647);
        send_request(ACT_INT, 8'd10,  31'd1234567);
        // Hex byte: letters and digits in both nibbles, addresses wrapping upward.
        send_request(ACT_HEX, 8'd0,   31'd0);
        send_request(ACT_HEX, 8'd10,  31'h0000_00FF);
        send_request(ACT_HEX, 8'd253, 31'h0000_00A5);
        send_request(ACT_HEX, 8'd255, 31'h7FFF_FF3C);

        drain_writes();

        // Random part. Once in a while the sender waits for the block to empty,
        // and one stretch runs with no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100 || n == 300) begin
                drain_writes();
            end
            calm <= (n >= 150 && n < 230);
            act = ACT_W'($urandom_range(3));
            send_request(act, pick_position(), pick_value(act));
        end

        calm <= 1'b0;
        drain_writes();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/lcdn_pkg.sv
hdl/lcdn_req_if.sv
hdl/lcdn_wr_if.sv
hdl/lcdn_ctrl.sv
hdl/lcdn_dp.sv
hdl/lcd_number_to_char_writes.sv
test/lcd_write_checker.sv
test/tb_lcd_number_to_char_writes.sv
